FILE: design/hbk_pkg.sv
// ============================================================================
// hbk_pkg
// Shared types, constants and usage translation for the boot keyboard
// event generator.
// ============================================================================
`default_nettype none

package hbk_pkg;

  // Usage slots in one boot report
  localparam int unsigned KEY_SLOTS = 6;

  // Event positions: three modifier groups, a down/press pair per new slot,
  // one up per released slot
  localparam int unsigned NUM_MOD_GROUPS = 3;
  localparam int unsigned NUM_EV = NUM_MOD_GROUPS + 3 * KEY_SLOTS;
  localparam int unsigned NEW_BASE = NUM_MOD_GROUPS;
  localparam int unsigned REL_BASE = NUM_MOD_GROUPS + 2 * KEY_SLOTS;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    KIND_DOWN  = 2'd0,
    KIND_UP    = 2'd1,
    KIND_PRESS = 2'd2
  } kind_e;

  // Modifier groups in event order: shift, ctrl, alt (left and right merged)
  localparam logic [7:0] GROUP_MASK [NUM_MOD_GROUPS] = '{8'h22, 8'h11, 8'h44};
  localparam logic signed [8:0] GROUP_CODE [NUM_MOD_GROUPS] = '{9'sd16, 9'sd17, 9'sd18};

  localparam logic signed [8:0] NO_CODE = -9'sd1;

  // Codes for usages 0x28 to 0x67
  localparam logic signed [8:0] MID_CODES [64] = '{
    9'sd13,  9'sd27,  9'sd8,   9'sd9,   9'sd32,  9'sd189, 9'sd61,  9'sd219,
    9'sd221, 9'sd220, NO_CODE, 9'sd59,  9'sd222, 9'sd192, 9'sd188, 9'sd190,
    9'sd191, 9'sd7,   9'sd112, 9'sd113, 9'sd114, 9'sd115, 9'sd116, 9'sd117,
    9'sd118, 9'sd119, 9'sd120, 9'sd121, 9'sd122, 9'sd123, NO_CODE, NO_CODE,
    NO_CODE, 9'sd45,  9'sd36,  9'sd33,  9'sd46,  9'sd35,  9'sd34,  9'sd39,
    9'sd37,  9'sd40,  9'sd38,  NO_CODE, 9'sd191, NO_CODE, 9'sd189, NO_CODE,
    9'sd13,  9'sd49,  9'sd50,  9'sd51,  9'sd52,  9'sd53,  9'sd54,  9'sd55,
    9'sd56,  9'sd57,  9'sd48,  9'sd190, NO_CODE, NO_CODE, NO_CODE, 9'sd61
  };

  // Codes for usages 0xE0 to 0xE7
  localparam logic signed [8:0] MOD_CODES [8] = '{
    9'sd17, 9'sd16, 9'sd18, 9'sd19, 9'sd17, 9'sd16, 9'sd18, 9'sd19
  };

  // One classified report, handed from front to back
  typedef struct packed {
    logic [NUM_MOD_GROUPS-1:0] mod_up;    // group was held, edge means release
    logic [NUM_EV-1:0]         ev_mask;   // pending event positions
    logic [KEY_SLOTS-1:0][7:0] cur_keys;  // usages of this report
    logic [KEY_SLOTS-1:0][7:0] prev_keys; // usages of the report before
  } job_t;

  // HID usage to key code
  function automatic logic signed [8:0] translate(input logic [7:0] u);
    logic signed [8:0] c;
    logic [7:0]        off;
    c   = NO_CODE;
    off = u - 8'h28;
    if (u >= 8'h04 && u <= 8'h1D) begin
      c = $signed({1'b0, u}) + 9'sd61;        // letters
    end else if (u >= 8'h1E && u <= 8'h26) begin
      c = $signed({1'b0, u}) + 9'sd19;        // digits 1..9
    end else if (u == 8'h27) begin
      c = 9'sd48;                             // digit 0
    end else if (u >= 8'h28 && u <= 8'h67) begin
      c = MID_CODES[off[5:0]];
    end else if (u == 8'h9E) begin
      c = 9'sd13;
    end else if (u >= 8'hE0 && u <= 8'hE7) begin
      c = MOD_CODES[u[2:0]];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/hbk_front.sv
// ============================================================================
// hbk_front
// Takes reports, compares them with the report kept from the beat before and
// pushes the resulting event mask into the job queue.
// ============================================================================
`default_nettype none

module hbk_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output logic                                       ready_o,
  input  wire logic [7:0]                            mods_i,
  input  wire logic [hbk_pkg::KEY_SLOTS-1:0][7:0]    keys_i,
  input  wire logic                                  full_i,
  output logic                                       push_o,
  output hbk_pkg::job_t                              job_o
);

  localparam int unsigned K = hbk_pkg::KEY_SLOTS;

  logic [7:0]          prev_mods_q;
  logic [K-1:0][7:0]   prev_keys_q;
  logic [K-1:0]        new_hit, old_hit;
  logic                accept;

  assign ready_o = !full_i;
  assign accept  = valid_i && ready_o;

  // Membership of each slot in the other report
  always_comb begin
    new_hit = '0;
    old_hit = '0;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        if (keys_i[i] == prev_keys_q[j]) new_hit[i] = 1'b1;
        if (prev_keys_q[i] == keys_i[j]) old_hit[i] = 1'b1;
      end
    end
  end

  // Classify: modifier edges, new slots, released slots
  always_comb begin
    job_o.ev_mask   = '0;
    job_o.mod_up    = '0;
    job_o.cur_keys  = keys_i;
    job_o.prev_keys = prev_keys_q;
    for (int g = 0; g < hbk_pkg::NUM_MOD_GROUPS; g++) begin
      job_o.mod_up[g]  = |(prev_mods_q & hbk_pkg::GROUP_MASK[g]);
      job_o.ev_mask[g] = job_o.mod_up[g] ^ (|(mods_i & hbk_pkg::GROUP_MASK[g]));
    end
    for (int i = 0; i < K; i++) begin
      job_o.ev_mask[hbk_pkg::NEW_BASE + 2*i]     = (keys_i[i] != 8'd0) && !new_hit[i];
      job_o.ev_mask[hbk_pkg::NEW_BASE + 2*i + 1] = (keys_i[i] != 8'd0) && !new_hit[i];
      job_o.ev_mask[hbk_pkg::REL_BASE + i]       = (prev_keys_q[i] != 8'd0) && !old_hit[i];
    end
  end

  // A report without any change leaves nothing to queue
  assign push_o = accept && (|job_o.ev_mask);

  // Previous report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mods_q <= '0;
      prev_keys_q <= '0;
    end else if (accept) begin
      prev_mods_q <= mods_i;
      prev_keys_q <= keys_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/hbk_fifo.sv
// ============================================================================
// hbk_fifo
// Short job queue that decouples report intake from event output.
// ============================================================================
`default_nettype none

module hbk_fifo #(
  parameter int unsigned Depth = hbk_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  hbk_pkg::job_t      data_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output hbk_pkg::job_t      data_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  hbk_pkg::job_t  mem_q [Depth];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o  = (count_q == CW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) count_q <= count_q + 1'b1;
      else if (!push_i && pop_i) count_q <= count_q - 1'b1;
    end
  end

  // Checks
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job queue written while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue read while empty");

endmodule

`default_nettype wire

FILE: design/hbk_back.sv
// ============================================================================
// hbk_back
// Walks the pending event mask of one job, lowest position first, and puts
// one translated event per beat into the output register.
// ============================================================================
`default_nettype none

module hbk_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           job_valid_i,
  input  hbk_pkg::job_t       job_i,
  output logic                pop_o,
  output logic                valid_o,
  input  wire logic           ready_i,
  output logic [1:0]          kind_o,
  output logic signed [8:0]   code_o,
  output logic                last_o
);

  localparam int unsigned K  = hbk_pkg::KEY_SLOTS;
  localparam int unsigned NE = hbk_pkg::NUM_EV;
  localparam int unsigned NG = hbk_pkg::NUM_MOD_GROUPS;

  logic [NE-1:0]        mask_q;
  logic [NG-1:0]        mod_up_q;
  logic [K-1:0][7:0]    cur_q, prev_q;

  logic                 found;
  logic [NE-1:0]        clr, rest;
  hbk_pkg::kind_e       sel_kind;
  logic [7:0]           sel_usage;
  logic                 sel_mod;
  logic signed [8:0]    sel_mod_code;
  logic signed [8:0]    code_d;
  logic                 busy, emit;

  logic                 out_valid_q;
  hbk_pkg::kind_e       kind_q;
  logic signed [8:0]    code_q;
  logic                 last_q;

  // Pick the lowest pending position
  always_comb begin
    found        = 1'b0;
    clr          = '0;
    sel_kind     = hbk_pkg::KIND_DOWN;
    sel_usage    = '0;
    sel_mod      = 1'b0;
    sel_mod_code = '0;
    for (int g = 0; g < NG; g++) begin
      if (!found && mask_q[g]) begin
        found        = 1'b1;
        clr[g]       = 1'b1;
        sel_mod      = 1'b1;
        sel_kind     = mod_up_q[g] ? hbk_pkg::KIND_UP : hbk_pkg::KIND_DOWN;
        sel_mod_code = hbk_pkg::GROUP_CODE[g];
      end
    end
    for (int i = 0; i < K; i++) begin
      for (int p = 0; p < 2; p++) begin
        if (!found && mask_q[hbk_pkg::NEW_BASE + 2*i + p]) begin
          found = 1'b1;
          clr[hbk_pkg::NEW_BASE + 2*i + p] = 1'b1;
          sel_kind  = (p == 1) ? hbk_pkg::KIND_PRESS : hbk_pkg::KIND_DOWN;
          sel_usage = cur_q[i];
        end
      end
    end
    for (int i = 0; i < K; i++) begin
      if (!found && mask_q[hbk_pkg::REL_BASE + i]) begin
        found = 1'b1;
        clr[hbk_pkg::REL_BASE + i] = 1'b1;
        sel_kind  = hbk_pkg::KIND_UP;
        sel_usage = prev_q[i];
      end
    end
  end

  assign rest   = mask_q & ~clr;
  assign code_d = sel_mod ? sel_mod_code : hbk_pkg::translate(sel_usage);

  // Load a new job only once the current one is drained
  assign busy  = |mask_q;
  assign pop_o = !busy && job_valid_i;
  assign emit  = busy && (!out_valid_q || ready_i);

  // Job state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (pop_o) begin
      mask_q <= job_i.ev_mask;
    end else if (emit) begin
      mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mod_up_q <= job_i.mod_up;
      cur_q    <= job_i.cur_keys;
      prev_q   <= job_i.prev_keys;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      kind_q <= sel_kind;
      code_q <= code_d;
      last_q <= (rest == '0);
    end
  end

  assign valid_o = out_valid_q;
  assign kind_o  = kind_q;
  assign code_o  = code_q;
  assign last_o  = last_q;

  // Checks
  a_emit_has_pick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (found && $onehot(clr)))
    else $error("event emitted without a pending position");

  a_last_on_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && (rest == '0)) |=> (valid_o && last_o && !busy))
    else $error("final event of a job not marked");

endmodule

`default_nettype wire

FILE: design/hid_boot_keyboard_event_gen.sv
// ============================================================================
// hid_boot_keyboard_event_gen
// Turns successive USB HID boot keyboard reports into ordered key events.
// ============================================================================
// Input channel (in_valid_i / in_ready_o): one boot report per beat, the
// modifier byte and six usage slots. Output channel (out_valid_o /
// out_ready_i): one key event per beat with its kind, translated code and a
// flag on the final event of its report. A report equal to the one before
// gives no events at all.
// Path: an accepted report goes through the job queue and the back end's job
// register (once the back end is free) to the output register.
// Throughput: within a report the back end gives one event per cycle while
// out_ready_i is high, and it loads a report only after the one before is
// drained. The front end takes a report per cycle while the job queue
// (QueueDepth entries) has room.
// Reset: the kept report is cleared to no modifiers and no keys held; queue
// and output register are emptied.
// Stall: while out_ready_i is low the event register holds; the queue fills
// and then in_ready_o drops.
// ============================================================================
`default_nettype none

module hid_boot_keyboard_event_gen #(
  parameter int unsigned QueueDepth = hbk_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          modifier_bits_i,
  input  wire logic [7:0]          key_slot_0_i,
  input  wire logic [7:0]          key_slot_1_i,
  input  wire logic [7:0]          key_slot_2_i,
  input  wire logic [7:0]          key_slot_3_i,
  input  wire logic [7:0]          key_slot_4_i,
  input  wire logic [7:0]          key_slot_5_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               event_kind_o,
  output logic signed [8:0]        event_code_o,
  output logic                     last_event_o
);

  logic [hbk_pkg::KEY_SLOTS-1:0][7:0] keys;
  hbk_pkg::job_t                      push_job, head_job;
  logic                               push, full, head_valid, pop;

  assign keys = {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                 key_slot_2_i, key_slot_1_i, key_slot_0_i};

  // Intake and classification
  hbk_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .mods_i  (modifier_bits_i),
    .keys_i  (keys),
    .full_i  (full),
    .push_o  (push),
    .job_o   (push_job)
  );

  // Job queue
  hbk_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .valid_o (head_valid),
    .pop_i   (pop),
    .data_o  (head_job)
  );

  // Event serializer
  hbk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .valid_o     (out_valid_o),
    .ready_i     (out_ready_i),
    .kind_o      (event_kind_o),
    .code_o      (event_code_o),
    .last_o      (last_event_o)
  );

endmodule

`default_nettype wire

FILE: bench/hid_boot_keyboard_event_gen_tb.sv
// ============================================================================
// hid_boot_keyboard_event_gen_tb
// Self-checking bench for the boot keyboard event generator. A scoreboard
// class keeps its own copy of the last report and turns every accepted
// report into the expected run of key events. Every event beat is then
// compared with the oldest expected event. The stimulus has a short
// directed part and then evolving random reports, with random idles on
// both channels and one long output stall.
// ============================================================================
`default_nettype none

module hid_boot_keyboard_event_gen_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD  = 4;
  localparam int unsigned SLOTS       = hbk_pkg::KEY_SLOTS;
  localparam int unsigned NUM_RANDOM  = 145;
  localparam int unsigned IDLE_PCT    = 23;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 30;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Modifier groups in event order: shift, ctrl, alt
  localparam logic [7:0]        GRP_MASK [3] = '{8'h22, 8'h11, 8'h44};
  localparam logic signed [8:0] GRP_CODE [3] = '{9'sd16, 9'sd17, 9'sd18};
  localparam logic signed [8:0] UNMAPPED     = -9'sd1;

  // Key codes for usages 0x28..0x67, -1 where unmapped
  localparam int MID_TABLE [64] = '{
    13,  27,  8,   9,   32,  189, 61,  219,
    221, 220, -1,  59,  222, 192, 188, 190,
    191, 7,   112, 113, 114, 115, 116, 117,
    118, 119, 120, 121, 122, 123, -1,  -1,
    -1,  45,  36,  33,  46,  35,  34,  39,
    37,  40,  38,  -1,  191, -1,  189, -1,
    13,  49,  50,  51,  52,  53,  54,  55,
    56,  57,  48,  190, -1,  -1,  -1,  61
  };

  // Key codes for the modifier usages 0xE0..0xE7
  localparam int MODKEY_TABLE [8] = '{17, 16, 18, 19, 17, 16, 18, 19};

  typedef struct {
    hbk_pkg::kind_e    kind;
    logic signed [8:0] code;
    logic              last;
  } key_event_t;

  // --------------------------------------------------------------------------
  // Scoreboard: report-to-event prediction and in-order event check
  // --------------------------------------------------------------------------
  class event_scoreboard;
    logic [7:0]            held_mods;
    logic [SLOTS-1:0][7:0] held_keys;
    key_event_t            pending_events [$];
    key_event_t            report_events [$];
    int unsigned           failures;

    function new();
      held_mods = '0;
      held_keys = '0;
      failures  = 0;
    endfunction

    function logic signed [8:0] usage_code(logic [7:0] u);
      int code;
      code = -1;
      if (u >= 8'h04 && u <= 8'h1D)      code = int'(u) + 61;   // A..Z
      else if (u >= 8'h1E && u <= 8'h26) code = int'(u) + 19;   // 1..9
      else if (u == 8'h27)               code = 48;             // 0
      else if (u >= 8'h28 && u <= 8'h67) code = MID_TABLE[u - 8'h28];
      else if (u == 8'h9E)               code = 13;
      else if (u >= 8'hE0 && u <= 8'hE7) code = MODKEY_TABLE[u - 8'hE0];
      return (code < 0) ? UNMAPPED : 9'(code);
    endfunction

    function bit is_held(logic [SLOTS-1:0][7:0] keys, logic [7:0] u);
      for (int i = 0; i < SLOTS; i++)
        if (keys[i] == u) return 1'b1;
      return 1'b0;
    endfunction

    function void add_event(hbk_pkg::kind_e kind, logic signed [8:0] code);
      key_event_t ev;
      ev.kind = kind;
      ev.code = code;
      ev.last = 1'b0;
      report_events.push_back(ev);
    endfunction

    // Accepted report beat: append its events to the expected stream
    function void note_report(logic [7:0] mods, logic [SLOTS-1:0][7:0] keys);
      bit was_on;
      bit now_on;
      report_events.delete();

      // group edges, one event at most per group
      for (int g = 0; g < 3; g++) begin
        was_on = (held_mods & GRP_MASK[g]) != 0;
        now_on = (mods & GRP_MASK[g]) != 0;
        if (was_on && !now_on) add_event(hbk_pkg::KIND_UP, GRP_CODE[g]);
        if (!was_on && now_on) add_event(hbk_pkg::KIND_DOWN, GRP_CODE[g]);
      end

      // newly pressed slots, duplicates each counted
      for (int i = 0; i < SLOTS; i++) begin
        if (keys[i] != 0 && !is_held(held_keys, keys[i])) begin
          add_event(hbk_pkg::KIND_DOWN, usage_code(keys[i]));
          add_event(hbk_pkg::KIND_PRESS, usage_code(keys[i]));
        end
      end

      // released slots of the report before
      for (int i = 0; i < SLOTS; i++)
        if (held_keys[i] != 0 && !is_held(keys, held_keys[i]))
          add_event(hbk_pkg::KIND_UP, usage_code(held_keys[i]));

      held_mods = mods;
      held_keys = keys;
      if (report_events.size() > 0) report_events[$].last = 1'b1;
      foreach (report_events[i]) pending_events.push_back(report_events[i]);
    endfunction

    // Accepted event beat: compare with the oldest expectation
    function void check_event(logic [1:0] kind, logic signed [8:0] code, logic last);
      key_event_t want;
      if (pending_events.size() == 0) begin
        $error("unexpected event: kind %0d code %0d last %0b", kind, code, last);
        failures++;
        return;
      end
      want = pending_events.pop_front();
      if (kind !== want.kind) begin
        $error("event_kind mismatch: expected %0d, actual %0d", want.kind, kind);
        failures++;
      end
      if (code !== want.code) begin
        $error("event_code mismatch: expected %0d, actual %0d", want.code, code);
        failures++;
      end
      if (last !== want.last) begin
        $error("last_event mismatch: expected %0b, actual %0b", want.last, last);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return pending_events.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            mods_drv;
  logic [SLOTS-1:0][7:0] keys_drv;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            event_kind;
  logic signed [8:0]     event_code;
  logic                  last_event;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  hid_boot_keyboard_event_gen dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .modifier_bits_i(mods_drv),
    .key_slot_0_i   (keys_drv[0]),
    .key_slot_1_i   (keys_drv[1]),
    .key_slot_2_i   (keys_drv[2]),
    .key_slot_3_i   (keys_drv[3]),
    .key_slot_4_i   (keys_drv[4]),
    .key_slot_5_i   (keys_drv[5]),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .event_kind_o   (event_kind),
    .event_code_o   (event_code),
    .last_event_o   (last_event)
  );

  event_scoreboard       sb;
  bit                    idle_on;
  bit                    hold_kick;
  int unsigned           hold_left;
  int unsigned           cycles;
  logic [7:0]            last_mods;
  logic [SLOTS-1:0][7:0] last_keys;

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Output side: random back-pressure plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready = 1'b0;
    end else if (hold_kick) begin
      hold_kick = 1'b0;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else begin
      out_ready = !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // event beat monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready)
      sb.check_event(event_kind, event_code, last_event);
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // One report beat, with random idle cycles ahead of it
  task automatic send_report(input logic [7:0] m,
                             input logic [7:0] k0, input logic [7:0] k1,
                             input logic [7:0] k2, input logic [7:0] k3,
                             input logic [7:0] k4, input logic [7:0] k5);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    mods_drv = m;
    keys_drv = {k5, k4, k3, k2, k1, k0};
    do @(posedge clk_i); while (!in_ready);
    sb.note_report(mods_drv, keys_drv);
    last_mods = mods_drv;
    last_keys = keys_drv;
  endtask

  // Empty slots, letters/digits/punctuation, some modifier-range and raw bytes;
  // a tiny pool makes duplicates likely
  function automatic logic [7:0] pick_usage();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return 8'h00;
    if (r < 35) return 8'($urandom_range(8'h06, 8'h04));
    if (r < 70) return 8'($urandom_range(8'h67, 8'h04));
    if (r < 85) return 8'($urandom_range(8'hFF, 8'hE0));
    return 8'($urandom());
  endfunction

  // Next report derived from the last one: keys held, moved, pressed,
  // released; some exact repeats and some pure noise
  task automatic send_random_report();
    logic [7:0]            m;
    logic [SLOTS-1:0][7:0] k;
    int unsigned           r;
    r = $urandom_range(99);
    if (r < 8) begin
      m = last_mods;
      k = last_keys;
    end else if (r < 18) begin
      m = 8'($urandom());
      k = 48'({$urandom(), $urandom()});
    end else begin
      m = last_mods;
      if ($urandom_range(2) == 0) m = m ^ 8'(1 << $urandom_range(7));
      for (int i = 0; i < SLOTS; i++) begin
        r = $urandom_range(99);
        if (r < 45)      k[i] = last_keys[i];
        else if (r < 60) k[i] = last_keys[$urandom_range(SLOTS - 1)];
        else             k[i] = pick_usage();
      end
    end
    send_report(m, k[0], k[1], k[2], k[3], k[4], k[5]);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb        = new();
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    mods_drv  = '0;
    keys_drv  = '0;
    out_ready = 1'b0;
    idle_on   = 1'b1;
    hold_kick = 1'b0;
    hold_left = 0;
    cycles    = 0;
    last_mods = '0;
    last_keys = '0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty report right after reset gives nothing
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // left shift down, then right shift joins: same group, no event
    send_report(8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_report(8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // shift up, ctrl and alt down in one report
    send_report(8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // all bits set: shift back down, gui bits silent
    send_report(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // gui only: three group releases
    send_report(8'h88, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // range edges of letters, digits, zero and the table start
    send_report(8'h00, 8'h04, 8'h1D, 8'h1E, 8'h26, 8'h27, 8'h28);
    // largest burst: three group presses, six new keys, six releases
    send_report(8'h77, 8'h67, 8'h9E, 8'hE0, 8'hE7, 8'hFF, 8'h01);
    // duplicate new usage gives two down/press pairs
    send_report(8'h77, 8'h05, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00);
    // duplicate released usage gives two ups
    send_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // unmapped usages, inside and around the table
    send_report(8'h00, 8'h32, 8'h68, 8'h9D, 8'h9F, 8'hDF, 8'h80);
    // kept usages in moved slots do not count as new
    send_report(8'h00, 8'h00, 8'h2D, 8'h68, 8'h32, 8'h2F, 8'h00);
    // unchanged report gives nothing
    send_report(8'h00, 8'h00, 8'h2D, 8'h68, 8'h32, 8'h2F, 8'h00);
    // low unmapped usages and modifier-range bytes past 0xE7
    send_report(8'h11, 8'h02, 8'h03, 8'hE8, 8'hF0, 8'hE3, 8'h9E);
    send_report(8'h00, 8'hFE, 8'h7F, 8'hAA, 8'h55, 8'h40, 8'h20);

    // random with idles, except for a stretch with none
    for (int n = 0; n < NUM_RANDOM; n++) begin
      idle_on = !(n >= 50 && n < 90);
      if (n == 110) hold_kick = 1'b1;
      send_random_report();
    end

    @(negedge clk_i);
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sb.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
